FILE: hdl/rdq_pkg.sv
package rdq_pkg;

  // Word widths fixed by the command format.
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  // Default ring depth.
  localparam int DEFAULT_DEPTH = 1024;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DATA  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Command word.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
  } out_word_t;

  // Storage strobes from the pointer control to the ring memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: hdl/rdq_store.sv
module rdq_store import rdq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  mem_ctl_t                 ctl,
  input  logic [AW-1:0]            addr,
  input  logic signed [DATA_W-1:0] wdata,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  // One port: a command either writes or reads, never both.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/rdq_ctrl.sv
module rdq_ctrl import rdq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  in_word_t                 cmd,
  output logic [STAT_W-1:0]        status,
  output mem_ctl_t                 mem_ctl,
  output logic [AW-1:0]            mem_addr,
  output logic signed [DATA_W-1:0] mem_wdata
);

  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rev_r, rev_nxt;

  logic          empty, full;
  logic          phys_front;
  logic [AW-1:0] head_inc, head_dec;
  logic [AW:0]   sum_wr, sum_rd;
  logic [AW-1:0] tail_wr, tail_rd;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == FULL_CNT);

  // Neighbor positions of the physical front, wrapping around the ring.
  assign head_inc = (head_r == LAST_POS) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST_POS : head_r - AW'(1);

  // Slot just past the last entry, and the last entry itself.
  assign sum_wr  = {1'b0, head_r} + (AW + 1)'(cnt_r);
  assign sum_rd  = sum_wr - (AW + 1)'(1);
  assign tail_wr = (sum_wr >= DEPTH_W) ? AW'(sum_wr - DEPTH_W) : sum_wr[AW-1:0];
  assign tail_rd = (sum_rd >= DEPTH_W) ? AW'(sum_rd - DEPTH_W) : sum_rd[AW-1:0];

  // The reverse flag swaps which physical end a logical end maps to.
  assign phys_front = ((cmd.mode == MODE_POP_FRONT) || (cmd.mode == MODE_PUSH_FRONT)) ^ rev_r;

  assign mem_wdata = cmd.value;

  // Command decode: status, storage access and next pointer state.
  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    rev_nxt       = rev_r;
    status        = ST_DONE;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    mem_addr      = head_r;
    unique case (cmd.mode) inside
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          status        = ST_DATA;
          mem_ctl.rd_en = acc;
          cnt_nxt       = cnt_r - CW'(1);
          if (phys_front) begin
            mem_addr = head_r;
            head_nxt = head_inc;
          end else begin
            mem_addr = tail_rd;
          end
        end
      end
      MODE_REVERSE: begin
        if (!empty) begin
          rev_nxt = ~rev_r;
        end
      end
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mem_ctl.wr_en = acc;
          cnt_nxt       = cnt_r + CW'(1);
          if (phys_front) begin
            mem_addr = head_dec;
            head_nxt = head_dec;
          end else begin
            mem_addr = tail_wr;
          end
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // Pointer, count and direction registers advance only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      rev_r  <= 1'b0;
    end else if (acc) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      rev_r  <= rev_nxt;
    end
  end

`ifndef SYNTH
  // The count never exceeds the ring depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count above depth");

  // The front position always lies inside the ring.
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < DEPTH_W)
    else $error("head position outside ring");

  // A successful pop removes exactly one entry.
  a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (status == ST_DATA) |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("pop did not decrement count");

  // Without an accepted word the queue state holds.
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(cnt_r) && $stable(head_r) && $stable(rev_r))
    else $error("queue state changed while idle");

  // Storage is never written and read by the same word.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("simultaneous read and write");
`endif

endmodule

FILE: hdl/reversible_deque.sv
// Double-ended queue of signed 32-bit words in a ring of DEPTH entries.
// Each command word (pop back, pop front, reverse, push back, push front)
// gives exactly one result word. One command is taken every cycle while the
// result side keeps up. A result word passes a middle stage on its way to the
// output register: the accepting edge updates the pointers and does the
// single-port ring memory access, and a later edge, once the output register is
// free, moves the registered read data into it. Reverse only toggles a
// direction flag. A pop on an empty queue reports empty, a push on a full
// ring is dropped and reports full. No clearing pass is needed after reset.
module reversible_deque import rdq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                     acc;
  logic                     s1_adv;
  logic [STAT_W-1:0]        status;
  mem_ctl_t                 mem_ctl;
  logic [AW-1:0]            mem_addr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic signed [DATA_W-1:0] mem_rdata;

  logic                     s1_valid_r, s1_valid_nxt;
  logic [STAT_W-1:0]        s1_status_r;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r;

  // Handshake: the middle stage moves on when the output register is free.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign acc      = in_valid && !in_stall;

  rdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cmd       (in_word),
    .status    (status),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  rdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign s1_valid_nxt  = acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  // Valid flags of the middle stage and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of both stages; data is zero unless a value was popped.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status_r <= status;
    end
    if (s1_adv) begin
      out_word_r.status <= s1_status_r;
      out_word_r.data   <= (s1_status_r == ST_DATA) ? mem_rdata : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: dv/testbench.sv
module testbench import rdq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // The three command codes that the block ignores.
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int RING_DEPTH = DEFAULT_DEPTH;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER = 400;

  // Mirror of the deque: ring contents, pointers and direction, plus the
  // result words still owed by the block.
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [RING_DEPTH];
    int unsigned head;
    int unsigned count;
    bit reversed;
    out_word_t owed_q[$];
    int unsigned noted;
    int unsigned errors;

    function void note_command(in_word_t w);
      out_word_t r;
      bit phys_front;
      r.status = ST_DONE;
      r.data = '0;
      noted++;
      case (w.mode) inside
        MODE_POP_BACK, MODE_POP_FRONT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // The direction flag swaps which physical end a pop takes from.
            phys_front = (w.mode == MODE_POP_FRONT) != reversed;
            if (phys_front) begin
              r.data = ring[head];
              head = (head + 1) % RING_DEPTH;
            end else begin
              r.data = ring[(head + count - 1) % RING_DEPTH];
            end
            count--;
            r.status = ST_DATA;
          end
        end
        MODE_REVERSE: begin
          if (count != 0) reversed = !reversed;
        end
        MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
          if (count >= RING_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            phys_front = (w.mode == MODE_PUSH_FRONT) != reversed;
            if (phys_front) begin
              head = (head + RING_DEPTH - 1) % RING_DEPTH;
              ring[head] = w.value;
            end else begin
              ring[(head + count) % RING_DEPTH] = w.value;
            end
            count++;
          end
        end
        default: begin
        end
      endcase
      owed_q = {owed_q, r};
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (owed_q.size() == 0) begin
        $error("result word with none owed: status %0d, data %0d", got.status, got.data);
        errors++;
        return;
      end
      want = owed_q[0];
      owed_q.delete(0);
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.data !== want.data) begin
        $error("data mismatch: expected %0d, got %0d", want.data, got.data);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  deque_scoreboard sb = new();
  int unsigned idle_cycles;
  int unsigned burst_left;

  reversible_deque dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t make_word(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v);
    in_word_t w;
    w.mode = m;
    w.value = v;
    return w;
  endfunction

  // Mostly random values, with the extremes showing up often.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {1'b0, {(DATA_W-1){1'b1}}};
      3: return {1'b1, {(DATA_W-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  // Percentages for push, pop and reverse; what is left goes to ignored codes.
  function automatic logic [MODE_W-1:0] pick_mode(int push_pct, int pop_pct, int rev_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    if (r < push_pct + pop_pct + rev_pct) return MODE_REVERSE;
    case ($urandom_range(2))
      0: return MODE_SPARE_5;
      1: return MODE_SPARE_6;
      default: return MODE_SPARE_7;
    endcase
  endfunction

  // Offer one command word and hold it until taken; a gap may follow.
  task automatic send_item(input in_word_t w);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(40);
      case ($urandom_range(9)) inside
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 4);
        8: gap = $urandom_range(5, 15);
        default: gap = $urandom_range(20, 40);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_word.mode <= MODE_W'($urandom);
        in_word.value <= $urandom;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Result side stalls in stretches of differing character, plus one long
  // hold-off that lets the block back up into its input.
  initial begin
    int unsigned stretch;
    int unsigned kind;
    int unsigned period;
    bit held_off;
    out_stall = 1'b0;
    held_off = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held_off && sb.noted >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        stretch = $urandom_range(20, 200);
        kind = $urandom_range(3);
        period = $urandom_range(1, 6);
        for (int i = 0; i < stretch; i++) begin
          case (kind)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(2) == 0);
            2: out_stall <= ((i / period) % 2 == 1);
            default: out_stall <= ($urandom_range(4) != 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // Both handshakes are sampled at the rising edge; the watchdog counts
  // cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_command(in_word);
      if (out_valid && !out_stall) sb.check_result(out_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[reversible_deque] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    in_word_t directed[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    idle_cycles = 0;
    burst_left = 0;

    // Empty-queue cases, ignored codes, extremes, both directions.
    directed = {directed, make_word(MODE_POP_BACK, pick_value())};
    directed = {directed, make_word(MODE_POP_FRONT, pick_value())};
    directed = {directed, make_word(MODE_REVERSE, pick_value())};
    directed = {directed, make_word(MODE_SPARE_5, '1)};
    directed = {directed, make_word(MODE_SPARE_6, '0)};
    directed = {directed, make_word(MODE_SPARE_7, pick_value())};
    directed = {directed, make_word(MODE_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}})};
    directed = {directed, make_word(MODE_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}})};
    directed = {directed, make_word(MODE_PUSH_BACK, '1)};
    directed = {directed, make_word(MODE_PUSH_FRONT, '0)};
    directed = {directed, make_word(MODE_REVERSE, '1)};
    directed = {directed, make_word(MODE_POP_FRONT, '1)};
    directed = {directed, make_word(MODE_POP_BACK, '0)};
    directed = {directed, make_word(MODE_REVERSE, '0)};
    directed = {directed, make_word(MODE_POP_FRONT, pick_value())};
    directed = {directed, make_word(MODE_POP_BACK, pick_value())};
    directed = {directed, make_word(MODE_POP_BACK, pick_value())};
    directed = {directed, make_word(MODE_PUSH_FRONT, 32'sd1)};
    directed = {directed, make_word(MODE_REVERSE, pick_value())};
    directed = {directed, make_word(MODE_PUSH_FRONT, 32'sd2)};
    directed = {directed, make_word(MODE_POP_BACK, pick_value())};
    directed = {directed, make_word(MODE_POP_FRONT, pick_value())};
    directed = {directed, make_word(MODE_POP_FRONT, pick_value())};
    directed = {directed, make_word(MODE_REVERSE, pick_value())};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_item(directed[i]);

    // Balanced traffic near empty, then fill the ring, hammer it while full,
    // and finally drain with pops dominating.
    repeat (100) send_item(make_word(pick_mode(45, 40, 10), pick_value()));
    while (sb.count < RING_DEPTH) send_item(make_word(pick_mode(94, 3, 2), pick_value()));
    repeat (15) send_item(make_word(pick_mode(80, 10, 8), pick_value()));
    repeat (120) send_item(make_word(pick_mode(15, 80, 4), pick_value()));

    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("[reversible_deque] OK");
    end else begin
      $display("[reversible_deque] ERROR");
    end
    $finish;
  end

endmodule
